[hw/rtl/pjwd_pkg.sv]
// ----------------------------------------------------------------------------
// pjwd_pkg: shared types and constants for the job-to-worker dispatcher
// Request and error codes, job status codes and the front-to-back item.
// ----------------------------------------------------------------------------
package pjwd_pkg;
  localparam int unsigned MaxJobsDef    = 64;
  localparam int unsigned MaxWorkersDef = 16;
  localparam int unsigned QDepth        = 2;

  typedef enum logic [2:0] {
    REQ_ADD   = 3'd0,
    REQ_FREE  = 3'd1,
    REQ_DISP  = 3'd2,
    REQ_SOLVE = 3'd3,
    REQ_QUERY = 3'd4,
    REQ_BAD5  = 3'd5,
    REQ_BAD6  = 3'd6,
    REQ_BAD7  = 3'd7
  } req_t;

  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_INV  = 2'd1;
  localparam logic [1:0] ERR_FULL = 2'd2;

  localparam logic [1:0] ST_QUEUED     = 2'd0;
  localparam logic [1:0] ST_INTERVENED = 2'd1;
  localparam logic [1:0] ST_SOLVED     = 2'd2;

  localparam logic [1:0] PRIO_UNKNOWN = 2'd3;

  typedef struct packed {
    req_t        req;
    logic [15:0] job_id;
    logic [1:0]  prio;
    logic [7:0]  worker_id;
  } item_t;
endpackage

[hw/rtl/pjwd_front.sv]
// ----------------------------------------------------------------------------
// pjwd_front: request intake
// Accept items, classify the request type and push them into a short queue.
// ----------------------------------------------------------------------------
module pjwd_front import pjwd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [15:0] in_job_id,
  input  logic [1:0]  in_job_priority,
  input  logic [7:0]  in_worker_id,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);
  item_t      mem_r [QDepth];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  item_t      item_in;

  always_comb begin
    item_in.req       = req_t'(in_req_type);
    item_in.job_id    = in_job_id;
    // priority matters only for adds; drop it elsewhere
    item_in.prio      = (in_req_type == REQ_ADD) ? in_job_priority : PRIO_UNKNOWN;
    item_in.worker_id = in_worker_id;
  end

  assign busy    = (cnt_r == 2'(QDepth));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= item_in;
  end

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QDepth)) else $error("queue count overflow");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> cnt_r == $past(cnt_r) + 2'd1) else $error("push lost");
`endif
endmodule

[hw/rtl/pjwd_back.sv]
// ----------------------------------------------------------------------------
// pjwd_back: request execution
// Run one item at a time against the job table, priority queues and
// free-worker queue; solve and query walk the table one entry at a time, reading then checking each.
// ----------------------------------------------------------------------------
module pjwd_back import pjwd_pkg::*; #(
  parameter int unsigned MAX_JOBS    = MaxJobsDef,
  parameter int unsigned MAX_WORKERS = MaxWorkersDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  output logic [1:0]  out_error_code,
  output logic [15:0] out_paired_job_id,
  output logic [7:0]  out_paired_worker_id,
  output logic [1:0]  out_job_status,
  output logic [4:0]  out_free_worker_count
);
  localparam int JW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam int WW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int FW = $clog2(MAX_WORKERS + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_DISP = 6'b000100,
    S_SCAN = 6'b001000,
    S_CHK  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  // job table and queues
  logic [15:0]   ids_m   [MAX_JOBS];
  logic [1:0]    sts_m   [MAX_JOBS];
  logic [7:0]    wrk_m   [MAX_JOBS];
  logic [JW-1:0] pq_m    [3][MAX_JOBS];
  logic [7:0]    free_m  [MAX_WORKERS];

  state_t        st_r, st_nxt;
  item_t         it_r;
  logic [CW-1:0] jcnt_r;
  logic [JW-1:0] ph_r [3];
  logic [CW-1:0] pc_r [3];
  logic [WW-1:0] fh_r;
  logic [FW-1:0] fc_r;
  logic [CW-1:0] idx_r;
  logic [1:0]    psel_r;
  logic [JW-1:0] head_rd_r;
  logic [7:0]    free_rd_r;
  logic [15:0]   id_rd_r;
  logic [1:0]    st_rd_r;
  logic [7:0]    wk_rd_r;
  logic          scan_vld_r;
  logic [JW-1:0] slot_r;

  logic [1:0]    err_r;
  logic [15:0]   pj_r;
  logic [7:0]    pw_r;
  logic [1:0]    js_r;
  logic          ov_r;

  logic [1:0]    psel;
  logic          any_q;
  logic [WW-1:0] ftail;
  logic [FW:0]   fsum;

  always_comb begin
    priority if (pc_r[0] != '0) psel = 2'd0;
    else if (pc_r[1] != '0)     psel = 2'd1;
    else                        psel = 2'd2;
    any_q = (pc_r[0] != '0) || (pc_r[1] != '0) || (pc_r[2] != '0);
    // head plus count stays below twice the depth; one subtract wraps it
    fsum = (FW+1)'(fh_r) + (FW+1)'(fc_r);
    if (fsum >= (FW+1)'(MAX_WORKERS)) fsum = fsum - (FW+1)'(MAX_WORKERS);
    ftail = WW'(fsum);
  end

  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign out_valid             = ov_r;
  assign out_error_code        = err_r;
  assign out_paired_job_id     = pj_r;
  assign out_paired_worker_id  = pw_r;
  assign out_job_status        = js_r;
  assign out_free_worker_count = 5'(fc_r);

  function automatic logic [JW-1:0] ring_inc(input logic [JW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(MAX_JOBS)) s = s - (CW+1)'(MAX_JOBS);
    return JW'(s);
  endfunction

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (q_valid) begin
        unique case (q_item.req)
          REQ_DISP:            st_nxt = S_RD;
          REQ_SOLVE, REQ_QUERY: st_nxt = S_SCAN;
          default:             st_nxt = S_DONE;
        endcase
      end
      S_RD:   st_nxt = S_DISP;
      S_DISP: st_nxt = S_DONE;
      S_SCAN: st_nxt = S_CHK;
      S_CHK:  st_nxt = (scan_vld_r && id_rd_r == it_r.job_id) ? S_DONE :
                       (idx_r >= jcnt_r) ? S_DONE : S_SCAN;
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      jcnt_r <= '0;
      for (int p = 0; p < 3; p++) begin
        ph_r[p] <= '0;
        pc_r[p] <= '0;
      end
      fh_r   <= '0;
      fc_r   <= '0;
      ov_r   <= 1'b0;
      scan_vld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          it_r  <= q_item;
          idx_r <= '0;
          scan_vld_r <= 1'b0;
          err_r <= ERR_OK;
          pj_r  <= '0;
          pw_r  <= '0;
          js_r  <= ST_QUEUED;
        end
        S_RD: begin
          // registered reads of queue head and free head
          psel_r    <= psel;
          head_rd_r <= pq_m[psel][ph_r[psel]];
          free_rd_r <= free_m[fh_r];
          if (!any_q || fc_r == '0) err_r <= ERR_INV;
        end
        S_DISP: if (err_r == ERR_OK) begin
          sts_m[head_rd_r] <= ST_INTERVENED;
          wrk_m[head_rd_r] <= free_rd_r;
          pj_r <= ids_m[head_rd_r];
          pw_r <= free_rd_r;
          ph_r[psel_r] <= ring_inc(ph_r[psel_r], CW'(1));
          pc_r[psel_r] <= pc_r[psel_r] - CW'(1);
          fh_r <= (fh_r == WW'(MAX_WORKERS - 1)) ? '0 : fh_r + WW'(1);
          fc_r <= fc_r - FW'(1);
        end
        S_SCAN: begin
          scan_vld_r <= (idx_r < jcnt_r);
          slot_r  <= JW'(idx_r);
          id_rd_r <= ids_m[JW'(idx_r)];
          st_rd_r <= sts_m[JW'(idx_r)];
          wk_rd_r <= wrk_m[JW'(idx_r)];
          idx_r   <= idx_r + CW'(1);
        end
        S_CHK: begin
          if (scan_vld_r && id_rd_r == it_r.job_id) begin
            if (it_r.req == REQ_QUERY) begin
              js_r <= st_rd_r;
            end else if (st_rd_r != ST_INTERVENED) begin
              err_r <= ERR_INV;
            end else if (fc_r >= FW'(MAX_WORKERS)) begin
              err_r <= ERR_FULL;
            end else begin
              sts_m[slot_r] <= ST_SOLVED;
              free_m[ftail] <= wk_rd_r;
              fc_r <= fc_r + FW'(1);
              pw_r <= wk_rd_r;
            end
          end else if (idx_r >= jcnt_r) begin
            err_r <= ERR_INV;
          end
        end
        S_DONE: begin
          ov_r <= 1'b1;
          if (it_r.req == REQ_ADD && err_r == ERR_OK) begin
            if (jcnt_r >= CW'(MAX_JOBS)) begin
              err_r <= ERR_FULL;
            end else begin
              ids_m[JW'(jcnt_r)] <= it_r.job_id;
              sts_m[JW'(jcnt_r)] <= ST_QUEUED;
              wrk_m[JW'(jcnt_r)] <= '0;
              jcnt_r <= jcnt_r + CW'(1);
              if (it_r.prio != PRIO_UNKNOWN) begin
                pq_m[it_r.prio][ring_inc(ph_r[it_r.prio], pc_r[it_r.prio])]
                  <= JW'(jcnt_r);
                pc_r[it_r.prio] <= pc_r[it_r.prio] + CW'(1);
              end
            end
          end else if (it_r.req == REQ_FREE && err_r == ERR_OK) begin
            if (fc_r >= FW'(MAX_WORKERS)) begin
              err_r <= ERR_FULL;
            end else begin
              free_m[ftail] <= it_r.worker_id;
              fc_r <= fc_r + FW'(1);
            end
          end else if ((it_r.req == REQ_BAD5) || (it_r.req == REQ_BAD6) ||
                       (it_r.req == REQ_BAD7)) begin
            err_r <= ERR_INV;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back-to-back results");
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE) |=> out_valid) else $error("result strobe missing");
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= FW'(MAX_WORKERS)) else $error("free count overflow");
  a_job_bound: assert property (@(posedge clk) disable iff (!rst_n)
    jcnt_r <= CW'(MAX_JOBS)) else $error("job count overflow");
`endif
endmodule

[hw/rtl/priority_job_to_worker_dispatcher_unit.sv]
// ----------------------------------------------------------------------------
// priority_job_to_worker_dispatcher_unit: strict-priority job dispatcher
// Three-level job queues paired with a FIFO of free workers.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_* with start high; the item is taken on an edge where busy is
//   low. A two-entry queue holds items while the execution engine works.
//   Each item yields exactly one result, shown for one cycle with out_valid;
//   the receiver cannot stall, so sample every strobe.
// Sequence, from the engine picking up an item to its result strobe:
//   add, free worker, bad request: straight to the result state;
//   dispatch: queue head read, update, result;
//   solve, query: a read and a check state per table entry, k entries read
//   (the matching slot plus one, else job_count, at least one), so up to
//   job_count entries, then the result; the table walk reads one entry at a
//   time through a single registered memory port.
// Reset: synchronous, active low; empties the job table (count to zero),
//   all priority queues, the free-worker queue and the intake queue.
// Free-worker count on every result is the occupancy after that item.
// ----------------------------------------------------------------------------
module priority_job_to_worker_dispatcher_unit import pjwd_pkg::*; #(
  parameter int unsigned MAX_JOBS    = MaxJobsDef,
  parameter int unsigned MAX_WORKERS = MaxWorkersDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [15:0] in_job_id,
  input  logic [1:0]  in_job_priority,
  input  logic [7:0]  in_worker_id,
  output logic        out_valid,
  output logic [1:0]  out_error_code,
  output logic [15:0] out_paired_job_id,
  output logic [7:0]  out_paired_worker_id,
  output logic [1:0]  out_job_status,
  output logic [4:0]  out_free_worker_count
);
  logic  q_valid, q_pop;
  item_t q_item;

  // intake: accept and classify
  pjwd_front u_front (
    .clk, .rst_n, .start, .busy,
    .in_req_type, .in_job_id, .in_job_priority, .in_worker_id,
    .q_valid, .q_item, .q_pop
  );

  // engine: execute one item at a time
  pjwd_back #(.MAX_JOBS(MAX_JOBS), .MAX_WORKERS(MAX_WORKERS)) u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop,
    .out_valid, .out_error_code, .out_paired_job_id,
    .out_paired_worker_id, .out_job_status, .out_free_worker_count
  );
endmodule
